[hdl/acs_pkg.sv]
// Shared types, opcodes and microcode ROM for the accumulator CPU step block.
// Used by acs_seq, acs_datapath and accumulator_cpu_step_top.
package acs_pkg;

  localparam int MEM_DEPTH_DEF = 256;
  localparam int WORD_W        = 8;
  localparam int UA_W          = 4;

  localparam logic [7:0] OP_STA = 8'h10;
  localparam logic [7:0] OP_LDA = 8'h20;
  localparam logic [7:0] OP_ADD = 8'h30;
  localparam logic [7:0] OP_OR  = 8'h40;
  localparam logic [7:0] OP_AND = 8'h50;
  localparam logic [7:0] OP_NOT = 8'h60;
  localparam logic [7:0] OP_JMP = 8'h80;
  localparam logic [7:0] OP_JN  = 8'h90;
  localparam logic [7:0] OP_JZ  = 8'hA0;
  localparam logic [7:0] OP_HLT = 8'hF0;

  localparam logic [1:0] MODE_LOAD    = 2'd0;
  localparam logic [1:0] MODE_READ    = 2'd1;
  localparam logic [1:0] MODE_EXEC    = 2'd2;
  localparam logic [1:0] MODE_RESTART = 2'd3;

  localparam logic [1:0] ASEL_IN    = 2'd0;
  localparam logic [1:0] ASEL_PC    = 2'd1;
  localparam logic [1:0] ASEL_PC1   = 2'd2;
  localparam logic [1:0] ASEL_RDATA = 2'd3;

  localparam logic [1:0] WR_NONE = 2'd0;
  localparam logic [1:0] WR_DATA = 2'd1;
  localparam logic [1:0] WR_STA  = 2'd2;

  localparam logic [1:0] RSEL_ZERO = 2'd0;
  localparam logic [1:0] RSEL_MEM  = 2'd1;
  localparam logic [1:0] RSEL_IR   = 2'd2;

  localparam logic [UA_W-1:0] UA_LOAD      = 4'd0;
  localparam logic [UA_W-1:0] UA_READ      = 4'd1;
  localparam logic [UA_W-1:0] UA_READ_DATA = 4'd2;
  localparam logic [UA_W-1:0] UA_RESTART   = 4'd3;
  localparam logic [UA_W-1:0] UA_FETCH     = 4'd4;
  localparam logic [UA_W-1:0] UA_ARG       = 4'd5;
  localparam logic [UA_W-1:0] UA_OPND      = 4'd6;
  localparam logic [UA_W-1:0] UA_RUN       = 4'd7;
  localparam logic [UA_W-1:0] UA_HALTED    = 4'd8;

  typedef struct packed {
    logic [1:0]      asel;
    logic [1:0]      wr;
    logic            ld_ir;
    logic            ld_arg;
    logic            restart;
    logic            exec;
    logic [1:0]      rsel;
    logic            jmp_halt;
    logic [UA_W-1:0] target;
    logic            done;
  } uword_t;

  typedef struct packed {
    uword_t uw;
    logic   adv;
  } ctrl_t;

  typedef struct packed {
    logic [WORD_W-1:0] acc;
    logic [WORD_W-1:0] pc;
    logic              zero;
    logic              neg;
    logic              halt;
    logic [WORD_W-1:0] rd;
  } res_t;

  function automatic uword_t ucode(input logic [UA_W-1:0] ua);
    uword_t w;
    w = '0;
    unique case (ua)
      UA_LOAD: begin
        w.asel = ASEL_IN;
        w.wr   = WR_DATA;
        w.rsel = RSEL_ZERO;
        w.done = 1'b1;
      end
      UA_READ: begin
        w.asel = ASEL_IN;
      end
      UA_READ_DATA: begin
        w.asel = ASEL_IN;
        w.rsel = RSEL_MEM;
        w.done = 1'b1;
      end
      UA_RESTART: begin
        w.restart = 1'b1;
        w.rsel    = RSEL_ZERO;
        w.done    = 1'b1;
      end
      UA_FETCH: begin
        w.asel     = ASEL_PC;
        w.jmp_halt = 1'b1;
        w.target   = UA_HALTED;
      end
      UA_ARG: begin
        w.asel  = ASEL_PC1;
        w.ld_ir = 1'b1;
      end
      UA_OPND: begin
        w.asel   = ASEL_RDATA;
        w.ld_arg = 1'b1;
        w.wr     = WR_STA;
      end
      UA_RUN: begin
        w.exec = 1'b1;
        w.rsel = RSEL_IR;
        w.done = 1'b1;
      end
      UA_HALTED: begin
        w.rsel = RSEL_ZERO;
        w.done = 1'b1;
      end
      default: begin
        w.rsel = RSEL_ZERO;
        w.done = 1'b1;
      end
    endcase
    return w;
  endfunction

  function automatic logic [UA_W-1:0] dispatch(input logic [1:0] mode);
    logic [UA_W-1:0] ua;
    ua = UA_LOAD;
    unique case (mode)
      MODE_LOAD:    ua = UA_LOAD;
      MODE_READ:    ua = UA_READ;
      MODE_EXEC:    ua = UA_FETCH;
      MODE_RESTART: ua = UA_RESTART;
      default:      ua = UA_LOAD;
    endcase
    return ua;
  endfunction

  // Reduce an 8-bit address below depth; depth >= 16 keeps the quotient in 4 bits.
  function automatic logic [7:0] wrap_addr(input logic [7:0] a, input int depth);
    logic [8:0] r;
    r = {1'b0, a};
    for (int k = 3; k >= 0; k--) begin
      if (int'(r) >= (depth << k)) begin
        r = r - 9'(depth << k);
      end
    end
    return r[7:0];
  endfunction

endpackage

[hdl/acs_ram.sv]
// Generic single-port RAM with enable and registered read data.
// Depends on nothing.
module acs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/acs_seq.sv]
// Microcode sequencer: step counter, ROM lookup, dispatch and halt jump.
// Depends on acs_pkg.
module acs_seq import acs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [1:0] in_mode,
  input  logic       halted,
  input  logic       out_block,
  output logic       busy,
  output logic       done_fire,
  output ctrl_t      ctrl
);

  logic            busy_r, busy_nxt;
  logic [UA_W-1:0] upc_r, upc_nxt;
  uword_t          uw;
  logic            adv;

  assign uw  = ucode(upc_r);
  assign adv = busy_r && !(uw.done && out_block);

  always_comb begin
    busy_nxt = busy_r;
    upc_nxt  = upc_r;
    if (in_fire) begin
      busy_nxt = 1'b1;
      upc_nxt  = dispatch(in_mode);
    end else if (adv) begin
      if (uw.done) begin
        busy_nxt = 1'b0;
      end else if (uw.jmp_halt && halted) begin
        upc_nxt = uw.target;
      end else begin
        upc_nxt = upc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      upc_r  <= UA_LOAD;
    end else begin
      busy_r <= busy_nxt;
      upc_r  <= upc_nxt;
    end
  end

  assign busy      = busy_r;
  assign done_fire = adv && uw.done;
  assign ctrl.uw   = uw;
  assign ctrl.adv  = adv;

endmodule

[hdl/acs_datapath.sv]
// Datapath: accumulator, program counter, halt mark, instruction registers, memory.
// Depends on acs_pkg and acs_ram.
module acs_datapath import acs_pkg::*; #(
  parameter int MEMORY_DEPTH = MEM_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic [7:0]        in_address,
  input  logic [WORD_W-1:0] in_data,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_start,
  input  ctrl_t             ctrl,
  output logic              halted,
  output res_t              res
);

  localparam int AW = $clog2(MEMORY_DEPTH);

  logic [7:0]        addr_r;
  logic [WORD_W-1:0] data_r;
  logic [7:0]        start_r;
  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic [7:0]        pc_r, pc_nxt;
  logic              halt_r, halt_nxt;
  logic [7:0]        ir_r;
  logic [7:0]        arg_r;

  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] wdata;
  logic [7:0]        raw_addr;
  logic [7:0]        wrapped;
  logic              we;
  logic [7:0]        pc1, pc2;

  assign pc1 = pc_r + 8'd1;
  assign pc2 = pc_r + 8'd2;

  always_comb begin
    unique case (ctrl.uw.asel)
      ASEL_IN:    raw_addr = addr_r;
      ASEL_PC:    raw_addr = pc_r;
      ASEL_PC1:   raw_addr = pc1;
      ASEL_RDATA: raw_addr = rdata;
      default:    raw_addr = addr_r;
    endcase
  end

  assign wrapped = wrap_addr(raw_addr, MEMORY_DEPTH);
  assign wdata   = (ctrl.uw.wr == WR_DATA) ? data_r : acc_r;
  assign we      = ctrl.adv && ((ctrl.uw.wr == WR_DATA) ||
                                ((ctrl.uw.wr == WR_STA) && (ir_r == OP_STA)));

  acs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MEMORY_DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (ctrl.adv),
    .we    (we),
    .addr  (wrapped[AW-1:0]),
    .wdata (wdata),
    .rdata (rdata)
  );

  always_comb begin
    acc_nxt  = acc_r;
    pc_nxt   = pc_r;
    halt_nxt = halt_r;
    if (ctrl.uw.restart) begin
      acc_nxt  = '0;
      pc_nxt   = start_r;
      halt_nxt = 1'b0;
    end else if (ctrl.uw.exec) begin
      unique case (ir_r)
        OP_STA: pc_nxt = pc2;
        OP_LDA: begin
          acc_nxt = rdata;
          pc_nxt  = pc2;
        end
        OP_ADD: begin
          acc_nxt = acc_r + rdata;
          pc_nxt  = pc2;
        end
        OP_OR: begin
          acc_nxt = acc_r | rdata;
          pc_nxt  = pc2;
        end
        OP_AND: begin
          acc_nxt = acc_r & rdata;
          pc_nxt  = pc2;
        end
        OP_NOT: begin
          acc_nxt = ~acc_r;
          pc_nxt  = pc1;
        end
        OP_JMP: pc_nxt = arg_r;
        OP_JN:  pc_nxt = acc_r[WORD_W-1] ? arg_r : pc2;
        OP_JZ:  pc_nxt = (acc_r == '0) ? arg_r : pc2;
        OP_HLT: halt_nxt = 1'b1;
        default: pc_nxt = pc1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      acc_r   <= '0;
      pc_r    <= '0;
      halt_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        start_r <= cfg_start;
      end
      if (ctrl.adv) begin
        acc_r  <= acc_nxt;
        pc_r   <= pc_nxt;
        halt_r <= halt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      addr_r <= in_address;
      data_r <= in_data;
    end
    if (ctrl.adv && ctrl.uw.ld_ir) begin
      ir_r <= rdata;
    end
    if (ctrl.adv && ctrl.uw.ld_arg) begin
      arg_r <= rdata;
    end
  end

  always_comb begin
    res.acc  = acc_nxt;
    res.pc   = pc_nxt;
    res.zero = (acc_nxt == '0);
    res.neg  = acc_nxt[WORD_W-1];
    res.halt = halt_nxt;
    unique case (ctrl.uw.rsel)
      RSEL_ZERO: res.rd = '0;
      RSEL_MEM:  res.rd = rdata;
      RSEL_IR:   res.rd = ir_r;
      default:   res.rd = '0;
    endcase
  end

  assign halted = halt_r;

endmodule

[hdl/accumulator_cpu_step_top.sv]
// A load or restart request runs its write or reset step; a read runs an address step
// and a data step; an execute runs the fetch, operand address and operand data accesses
// on the single-port memory plus the execute step, or the fetch and a halted step when
// halted. No new request is taken while one is in progress; one can be taken in the same
// cycle that out_valid rises. A held result stalls the last step until out_stall drops.
// Synchronous active-low reset clears accumulator, program counter, halt mark and
// start address; memory contents are undefined until written.
module accumulator_cpu_step_top import acs_pkg::*; #(
  parameter int MEMORY_DEPTH = MEM_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_mode,
  input  logic [7:0]        in_address,
  input  logic [WORD_W-1:0] in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] out_accumulator_value,
  output logic [7:0]        out_program_counter_value,
  output logic              out_zero_flag,
  output logic              out_negative_flag,
  output logic              out_halted_flag,
  output logic [WORD_W-1:0] out_read_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_start_address
);

  logic  busy;
  logic  in_fire;
  logic  done_fire;
  logic  halted;
  logic  out_block;
  ctrl_t ctrl;
  res_t  res;
  logic  out_valid_r;
  res_t  out_r;

  assign in_stall  = busy;
  assign in_fire   = in_valid && !busy;
  assign cfg_ready = 1'b1;
  assign out_block = out_valid_r && out_stall;

  acs_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_mode   (in_mode),
    .halted    (halted),
    .out_block (out_block),
    .busy      (busy),
    .done_fire (done_fire),
    .ctrl      (ctrl)
  );

  acs_datapath #(
    .MEMORY_DEPTH (MEMORY_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_address (in_address),
    .in_data    (in_data),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_start  (cfg_start_address),
    .ctrl       (ctrl),
    .halted     (halted),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      out_r <= res;
    end
  end

  assign out_valid                 = out_valid_r;
  assign out_accumulator_value     = out_r.acc;
  assign out_program_counter_value = out_r.pc;
  assign out_zero_flag             = out_r.zero;
  assign out_negative_flag         = out_r.neg;
  assign out_halted_flag           = out_r.halt;
  assign out_read_data             = out_r.rd;

endmodule

[tb/sv/accumulator_cpu_step_top_tb.sv]
// Self-checking bench for accumulator_cpu_step_top: an in-bench model of the 8-bit
// accumulator CPU predicts every result, with random idling and a long output hold-off.
// Depends on acs_pkg (opcodes, request modes, result struct) and the RTL under hdl/.
module accumulator_cpu_step_top_tb import acs_pkg::*; ();

  localparam int STUCK_LIMIT   = 2000;
  localparam int LONG_HOLD     = 150;
  localparam int LONG_HOLD_AT  = 600;
  localparam int PHASE_ITEMS   = 265;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] addr;
    logic [7:0] data;
  } cpu_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_mode = MODE_LOAD;
  logic [7:0]        in_address = '0;
  logic [WORD_W-1:0] in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [WORD_W-1:0] out_accumulator_value;
  logic [7:0]        out_program_counter_value;
  logic              out_zero_flag;
  logic              out_negative_flag;
  logic              out_halted_flag;
  logic [WORD_W-1:0] out_read_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [7:0]        cfg_start_address = '0;

  accumulator_cpu_step_top dut (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .in_valid                  (in_valid),
    .in_stall                  (in_stall),
    .in_mode                   (in_mode),
    .in_address                (in_address),
    .in_data                   (in_data),
    .out_valid                 (out_valid),
    .out_stall                 (out_stall),
    .out_accumulator_value     (out_accumulator_value),
    .out_program_counter_value (out_program_counter_value),
    .out_zero_flag             (out_zero_flag),
    .out_negative_flag         (out_negative_flag),
    .out_halted_flag           (out_halted_flag),
    .out_read_data             (out_read_data),
    .cfg_valid                 (cfg_valid),
    .cfg_ready                 (cfg_ready),
    .cfg_start_address         (cfg_start_address)
  );

  always #5 clk = ~clk;

  // CPU model state
  logic [7:0] cpu_memory [256];
  logic [7:0] cpu_acc = '0;
  logic [7:0] cpu_pc = '0;
  logic       cpu_halted = 1'b0;
  logic [7:0] start_addr_cfg = '0;

  cpu_req_t pending_items [$];
  res_t     expected_states [$];

  logic        quiet = 1'b0;
  logic [15:0] cycle_count = '0;
  wire         idle_window = cycle_count[8:7] != 2'b00;
  logic [3:0]  gap_left = '0;
  logic [7:0]  stall_left = '0;
  logic        long_hold_done = 1'b0;
  int          results_seen = 0;
  int          stuck_cycles = 0;
  int          mismatches = 0;
  int          items_accepted = 0;
  int          execs_accepted = 0;
  int          queued_total = 0;
  int          cfg_writes = 0;
  res_t        seen_state;
  logic        field_bad;

  function automatic res_t predict_cpu_step(input logic [1:0] mode, input logic [7:0] addr,
                                            input logic [7:0] data);
    res_t r;
    logic [7:0] op, arg, pc1, pc2;
    r = '0;
    case (mode)
      MODE_LOAD: cpu_memory[addr] = data;
      MODE_READ: r.rd = cpu_memory[addr];
      MODE_EXEC: begin
        if (!cpu_halted) begin
          pc1 = cpu_pc + 8'd1;
          pc2 = cpu_pc + 8'd2;
          op = cpu_memory[cpu_pc];
          arg = cpu_memory[pc1];
          r.rd = op;
          case (op)
            OP_STA: begin
              cpu_memory[arg] = cpu_acc;
              cpu_pc = pc2;
            end
            OP_LDA: begin
              cpu_acc = cpu_memory[arg];
              cpu_pc = pc2;
            end
            OP_ADD: begin
              cpu_acc = cpu_acc + cpu_memory[arg];
              cpu_pc = pc2;
            end
            OP_OR: begin
              cpu_acc = cpu_acc | cpu_memory[arg];
              cpu_pc = pc2;
            end
            OP_AND: begin
              cpu_acc = cpu_acc & cpu_memory[arg];
              cpu_pc = pc2;
            end
            OP_NOT: begin
              cpu_acc = ~cpu_acc;
              cpu_pc = pc1;
            end
            OP_JMP: cpu_pc = arg;
            OP_JN:  cpu_pc = cpu_acc[7] ? arg : pc2;
            OP_JZ:  cpu_pc = (cpu_acc == 8'd0) ? arg : pc2;
            OP_HLT: cpu_halted = 1'b1;
            default: cpu_pc = pc1;
          endcase
        end
      end
      default: begin
        cpu_pc = start_addr_cfg;
        cpu_acc = '0;
        cpu_halted = 1'b0;
      end
    endcase
    r.acc = cpu_acc;
    r.pc = cpu_pc;
    r.zero = (cpu_acc == 8'd0);
    r.neg = cpu_acc[7];
    r.halt = cpu_halted;
    return r;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 16'd1;
  end

  // driver: hold a stalled request, insert gap bursts, advance from the pending queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_states.push_back(predict_cpu_step(in_mode, in_address, in_data));
        items_accepted++;
        if (in_mode == MODE_EXEC) execs_accepted++;
      end
      if (in_valid && in_stall) begin
      end else if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 4'd1;
      end else if (!quiet && idle_window && $urandom_range(0, 4) == 0) begin
        in_valid <= 1'b0;
        gap_left <= 4'($urandom_range(0, 9));
      end else if (pending_items.size() != 0) begin
        in_valid <= 1'b1;
        in_mode <= pending_items[0].mode;
        in_address <= pending_items[0].addr;
        in_data <= pending_items[0].data;
        pending_items.delete(0);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall: one long hold-off plus random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= '0;
    end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
      out_stall <= 1'b1;
      stall_left <= 8'(LONG_HOLD - 1);
      long_hold_done <= 1'b1;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 8'd1;
    end else if (!quiet && idle_window && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= 8'($urandom_range(0, 9));
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic report_mismatch(input string what, input res_t exp, input res_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"MISMATCH (%s) result %0d: expected acc=%02h pc=%02h z=%b n=%b h=%b",
                " rd=%02h, got acc=%02h pc=%02h z=%b n=%b h=%b rd=%02h"},
               what, results_seen, exp.acc, exp.pc, exp.zero, exp.neg, exp.halt, exp.rd,
               got.acc, got.pc, got.zero, got.neg, got.halt, got.rd);
  endtask

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      seen_state.acc = out_accumulator_value;
      seen_state.pc = out_program_counter_value;
      seen_state.zero = out_zero_flag;
      seen_state.neg = out_negative_flag;
      seen_state.halt = out_halted_flag;
      seen_state.rd = out_read_data;
      if (expected_states.size() == 0) begin
        report_mismatch("no request pending", '0, seen_state);
      end else begin
        field_bad = (seen_state.acc !== expected_states[0].acc) ||
                    (seen_state.pc !== expected_states[0].pc) ||
                    (seen_state.zero !== expected_states[0].zero) ||
                    (seen_state.neg !== expected_states[0].neg) ||
                    (seen_state.halt !== expected_states[0].halt) ||
                    (seen_state.rd !== expected_states[0].rd);
        if (field_bad) report_mismatch("field", expected_states[0], seen_state);
        expected_states.delete(0);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      stuck_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("Timeout: no request or result moved for %0d cycles", STUCK_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic add_item(input logic [1:0] mode, input logic [7:0] addr,
                          input logic [7:0] data);
    cpu_req_t r;
    r.mode = mode;
    r.addr = addr;
    r.data = data;
    pending_items.push_back(r);
    queued_total++;
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_states.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_start_address(input logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_start_address <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    start_addr_cfg = value;
    cfg_writes++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h01;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_opcode();
    case ($urandom_range(0, 21))
      0, 1, 2: return OP_LDA;
      3, 4:    return OP_STA;
      5, 6, 7: return OP_ADD;
      8, 9:    return OP_OR;
      10, 11:  return OP_AND;
      12, 13:  return OP_NOT;
      14:      return OP_JMP;
      15, 16:  return OP_JN;
      17, 18:  return OP_JZ;
      19:      return OP_HLT;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic queue_program_run(input logic [7:0] base);
    logic [7:0] a, op, arg;
    int n_instr;
    a = base;
    n_instr = $urandom_range(2, 8);
    for (int i = 0; i < n_instr; i++) begin
      op = pick_opcode();
      add_item(MODE_LOAD, a, op);
      if (op inside {OP_JMP, OP_JN, OP_JZ}) begin
        arg = ($urandom_range(0, 2) == 0) ? 8'($urandom) :
              base + 8'($urandom_range(0, 2 * n_instr));
        add_item(MODE_LOAD, a + 8'd1, arg);
        a = a + 8'd2;
      end else if (op inside {OP_STA, OP_LDA, OP_ADD, OP_OR, OP_AND}) begin
        arg = base + 8'h40 + 8'($urandom_range(0, 7));
        add_item(MODE_LOAD, a + 8'd1, arg);
        a = a + 8'd2;
      end else begin
        a = a + 8'd1;
      end
    end
    repeat ($urandom_range(0, 3))
      add_item(MODE_LOAD, base + 8'h40 + 8'($urandom_range(0, 7)), pick_byte());
    add_item(MODE_RESTART, 8'($urandom), 8'($urandom));
    repeat ($urandom_range(3, 16)) begin
      if ($urandom_range(0, 7) == 0) add_item(MODE_READ, 8'($urandom), 8'($urandom));
      add_item(MODE_EXEC, 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    logic [7:0] image [256];
    logic [7:0] phase_starts [6];
    int goal;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_start_address(8'hFD);

    // fill all of memory, with a short program that wraps the counter past 0xFF
    for (int i = 0; i < 256; i++) image[i] = pick_byte();
    image[8'hFD] = OP_LDA;  image[8'hFE] = 8'h80; image[8'h80] = 8'hFF;
    image[8'hFF] = OP_JZ;   image[8'h00] = 8'h40;
    image[8'h01] = OP_ADD;  image[8'h02] = 8'h81; image[8'h81] = 8'h01;
    image[8'h03] = OP_JN;   image[8'h04] = 8'h40;
    image[8'h05] = OP_JZ;   image[8'h06] = 8'h10;
    image[8'h10] = OP_NOT;
    image[8'h11] = OP_JN;   image[8'h12] = 8'h20;
    image[8'h20] = OP_STA;  image[8'h21] = 8'h82;
    image[8'h22] = OP_AND;  image[8'h23] = 8'h83; image[8'h83] = 8'h5A;
    image[8'h24] = OP_OR;   image[8'h25] = 8'h84; image[8'h84] = 8'h81;
    image[8'h26] = 8'h07;
    image[8'h27] = OP_JMP;  image[8'h28] = 8'h30;
    image[8'h30] = OP_HLT;
    for (int i = 0; i < 256; i++) add_item(MODE_LOAD, 8'(i), image[i]);

    add_item(MODE_RESTART, 8'hFF, 8'hFF);
    repeat (15) add_item(MODE_EXEC, 8'h00, 8'h00);
    add_item(MODE_READ, 8'h82, 8'h00);
    add_item(MODE_READ, 8'h00, 8'hFF);
    add_item(MODE_READ, 8'hFF, 8'h00);
    add_item(MODE_LOAD, 8'hFF, 8'h00);
    add_item(MODE_LOAD, 8'h00, 8'hFF);
    add_item(MODE_RESTART, 8'h00, 8'h00);

    phase_starts[0] = 8'h00;
    phase_starts[1] = 8'hFF;
    phase_starts[2] = 8'($urandom);
    phase_starts[3] = 8'h80;
    phase_starts[4] = 8'($urandom);
    phase_starts[5] = 8'($urandom);
    for (int p = 0; p < 6; p++) begin
      drain();
      if (p == 5) quiet <= 1'b1;
      write_start_address(phase_starts[p]);
      goal = queued_total + PHASE_ITEMS;
      while (queued_total < goal) begin
        if ($urandom_range(0, 4) != 0) begin
          queue_program_run(phase_starts[p]);
        end else begin
          repeat ($urandom_range(1, 6))
            add_item(2'($urandom), 8'($urandom), pick_byte());
        end
      end
    end

    drain();
    $display("Ran %0d requests (%0d executes) over %0d start-address settings,",
             items_accepted, execs_accepted, cfg_writes);
    $display("with idling, a long hold-off and wraps; %0d results checked, %0d mismatches",
             results_seen, mismatches);
    if (mismatches == 0 && expected_states.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[accumulator_cpu_step_top.f]
hdl/acs_pkg.sv
hdl/acs_ram.sv
hdl/acs_seq.sv
hdl/acs_datapath.sv
hdl/accumulator_cpu_step_top.sv
tb/sv/accumulator_cpu_step_top_tb.sv
